@@ rtl/core/vtr_pkg.sv @@
`default_nettype none

package vtr_pkg;

    // Default build parameters
    localparam int MAX_SIDE_DEF   = 32;
    localparam int VALUE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed field widths
    localparam int SRC_W     = 6;
    localparam int DST_W     = 8;
    localparam int COORD_W   = 8;
    localparam int LIDX_W    = 15;
    localparam int LVAL_W    = 16;
    localparam int SAMPLE_W  = 16;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // Quotient bits resolved per divider stage
    localparam int DIV_STEPS = 8;

    // Register reset values
    localparam logic [SRC_W-1:0] SRC_RESET  = 6'd32;
    localparam logic [DST_W-1:0] DST_RESET  = 8'd32;

    // Item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Interpolation modes
    localparam logic MODE_NEAREST   = 1'b0;
    localparam logic MODE_TRILINEAR = 1'b1;

    localparam logic MODE_RESET = MODE_TRILINEAR;

    // Configuration register map (word index)
    typedef enum logic [2:0] {
        REG_SRC_X,
        REG_SRC_Y,
        REG_SRC_Z,
        REG_DST_X,
        REG_DST_Y,
        REG_DST_Z,
        REG_MODE
    } cfg_reg_t;

endpackage

`default_nettype wire

@@ rtl/core/vtr_ram.sv @@
`default_nettype none

module vtr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/vtr_div_step.sv @@
`default_nettype none

// Restoring division, STEPS quotient bits per pass, 8-bit divisor
module vtr_div_step #(
    parameter int STEPS = vtr_pkg::DIV_STEPS
) (
    input  wire logic [vtr_pkg::DST_W-1:0] rem_in,
    input  wire logic [STEPS-1:0]          bits_in,
    input  wire logic [vtr_pkg::DST_W-1:0] den,
    output logic      [vtr_pkg::DST_W-1:0] rem_out,
    output logic      [STEPS-1:0]          quot_out
);

    localparam int RW = vtr_pkg::DST_W;

    always_comb
    begin
        logic [RW-1:0] r;
        logic [RW:0]   t;
        r = rem_in;
        quot_out = '0;
        for (int i = 0; i < STEPS; i++)
        begin
            t = {r, bits_in[STEPS-1-i]};
            if (t >= {1'b0, den})
            begin
                t = t - {1'b0, den};
                quot_out[STEPS-1-i] = 1'b1;
            end
            r = t[RW-1:0];
        end
        rem_out = r;
    end

endmodule

`default_nettype wire

@@ rtl/core/volume_trilinear_resampler_unit.sv @@
// Volume resampler: holds a source volume of signed voxels (written by load
// transactions, linear index z*MAX_SIDE^2 + y*MAX_SIDE + x, MAX_SIDE a power of
// two) and answers each sample transaction with one trilinear or nearest
// neighbour value at out*src_size/dst_size on each axis. The block is a fully
// pipelined datapath: a transaction of either kind is accepted in every cycle
// the output is not stalled. A sample passes the entry register, the per-axis
// coordinate divider stages resolving 8 quotient bits per stage, the index
// stage, the RAM read, the x, y and z blend stages and the output register.
// The volume lives in eight RAM banks split by the parity of x, y and z, so
// all eight neighbours are read in the same cycle. Loads write the banks at the
// same pipeline point where samples read them, so order is kept. The volume is
// not cleared; a voxel must be loaded before it is sampled. Configuration goes
// through an APB-style port and must only be written while the pipeline is empty.
`default_nettype none

module volume_trilinear_resampler_unit #(
    parameter int MAX_SIDE   = vtr_pkg::MAX_SIDE_DEF,
    parameter int VALUE_BITS = vtr_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS  = vtr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            kind,
    input  wire logic [vtr_pkg::LIDX_W-1:0]      load_index,
    input  wire logic signed [vtr_pkg::LVAL_W-1:0] load_value,
    input  wire logic [vtr_pkg::COORD_W-1:0]     out_x,
    input  wire logic [vtr_pkg::COORD_W-1:0]     out_y,
    input  wire logic [vtr_pkg::COORD_W-1:0]     out_z,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [vtr_pkg::SAMPLE_W-1:0]  sample_value,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [vtr_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [vtr_pkg::PDATA_W-1:0]     pwdata,
    output logic      [vtr_pkg::PDATA_W-1:0]     prdata,
    output logic                                 pready
);

    localparam int F     = FRAC_BITS;
    localparam int VB    = VALUE_BITS;
    localparam int SB    = $clog2(MAX_SIDE);
    localparam int HB    = (SB > 1) ? SB - 1 : 1;
    localparam int SEW   = $clog2(MAX_SIDE + 1);
    localparam int PW    = vtr_pkg::COORD_W + SEW;
    localparam int QB    = PW + F;
    localparam int STEPS = vtr_pkg::DIV_STEPS;
    localparam int NS    = (QB + STEPS - 1) / STEPS;
    localparam int DB    = NS * STEPS;
    localparam int LW    = VB + F + 1;
    localparam int IXW   = (3 * SB > vtr_pkg::LIDX_W) ? 3 * SB : vtr_pkg::LIDX_W;
    localparam longint VOL_DEPTH = longint'(MAX_SIDE) * MAX_SIDE * MAX_SIDE;
    localparam int BANK_DEPTH = 2 ** (3 * HB);
    localparam int DW    = vtr_pkg::DST_W;

    localparam logic [QB:0]    HALF = (QB+1)'(1) << (F - 1);
    localparam logic [LW-1:0]  BIAS = LW'((longint'(1) << F) - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [vtr_pkg::SRC_W-1:0] src_x_reg, src_y_reg, src_z_reg;
    logic [vtr_pkg::DST_W-1:0] dst_x_reg, dst_y_reg, dst_z_reg;
    logic                      mode_reg;
    logic                      cfg_write;
    vtr_pkg::cfg_reg_t         cfg_sel;

    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = vtr_pkg::cfg_reg_t'(paddr[4:2]);
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_x_reg <= vtr_pkg::SRC_RESET;
            src_y_reg <= vtr_pkg::SRC_RESET;
            src_z_reg <= vtr_pkg::SRC_RESET;
            dst_x_reg <= vtr_pkg::DST_RESET;
            dst_y_reg <= vtr_pkg::DST_RESET;
            dst_z_reg <= vtr_pkg::DST_RESET;
            mode_reg  <= vtr_pkg::MODE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                vtr_pkg::REG_SRC_X: src_x_reg <= pwdata[vtr_pkg::SRC_W-1:0];
                vtr_pkg::REG_SRC_Y: src_y_reg <= pwdata[vtr_pkg::SRC_W-1:0];
                vtr_pkg::REG_SRC_Z: src_z_reg <= pwdata[vtr_pkg::SRC_W-1:0];
                vtr_pkg::REG_DST_X: dst_x_reg <= pwdata[vtr_pkg::DST_W-1:0];
                vtr_pkg::REG_DST_Y: dst_y_reg <= pwdata[vtr_pkg::DST_W-1:0];
                vtr_pkg::REG_DST_Z: dst_z_reg <= pwdata[vtr_pkg::DST_W-1:0];
                vtr_pkg::REG_MODE:  mode_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (cfg_sel)
            vtr_pkg::REG_SRC_X: prdata = vtr_pkg::PDATA_W'(src_x_reg);
            vtr_pkg::REG_SRC_Y: prdata = vtr_pkg::PDATA_W'(src_y_reg);
            vtr_pkg::REG_SRC_Z: prdata = vtr_pkg::PDATA_W'(src_z_reg);
            vtr_pkg::REG_DST_X: prdata = vtr_pkg::PDATA_W'(dst_x_reg);
            vtr_pkg::REG_DST_Y: prdata = vtr_pkg::PDATA_W'(dst_y_reg);
            vtr_pkg::REG_DST_Z: prdata = vtr_pkg::PDATA_W'(dst_z_reg);
            vtr_pkg::REG_MODE:  prdata = vtr_pkg::PDATA_W'(mode_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective sizes per axis
    // ------------------------------------------------------------------
    function automatic logic [SEW-1:0] eff_src(input logic [vtr_pkg::SRC_W-1:0] s);
        logic [SEW-1:0] r;
        if (s == '0)
        begin
            r = SEW'(1);
        end
        else if (int'(s) > MAX_SIDE)
        begin
            r = SEW'(MAX_SIDE);
        end
        else
        begin
            r = SEW'(s);
        end
        return r;
    endfunction

    logic [SEW-1:0]            src_arr  [0:2];
    logic [SB-1:0]             last_arr [0:2];
    logic [DW-1:0]             dst_arr  [0:2];
    logic [vtr_pkg::COORD_W-1:0] crd_arr [0:2];

    assign src_arr[0] = eff_src(src_x_reg);
    assign src_arr[1] = eff_src(src_y_reg);
    assign src_arr[2] = eff_src(src_z_reg);
    assign dst_arr[0] = (dst_x_reg == '0) ? DW'(1) : dst_x_reg;
    assign dst_arr[1] = (dst_y_reg == '0) ? DW'(1) : dst_y_reg;
    assign dst_arr[2] = (dst_z_reg == '0) ? DW'(1) : dst_z_reg;
    assign crd_arr[0] = out_x;
    assign crd_arr[1] = out_y;
    assign crd_arr[2] = out_z;

    // ------------------------------------------------------------------
    // Pipeline control: whole pipe moves when the output can move
    // ------------------------------------------------------------------
    logic advance;
    logic out_valid_reg;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // ------------------------------------------------------------------
    // Entry stage and coordinate divider stages
    // ------------------------------------------------------------------
    logic                        dv_valid_reg [0:NS];
    logic                        dv_kind_reg  [0:NS];
    logic [vtr_pkg::LIDX_W-1:0]  dv_lidx_reg  [0:NS];
    logic [vtr_pkg::LVAL_W-1:0]  dv_lval_reg  [0:NS];
    logic [DB-1:0]               num_reg      [0:NS][0:2];
    logic [DW-1:0]               rem_reg      [0:NS][0:2];
    logic [DB-1:0]               quot_reg     [0:NS][0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            dv_valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dv_kind_reg[0] <= kind;
            dv_lidx_reg[0] <= load_index;
            dv_lval_reg[0] <= load_value;
        end
    end

    genvar a, k, b, yz;
    generate
        // numerator = out * src, shifted up by the fraction bits
        for (a = 0; a < 3; a++)
        begin : g_entry
            logic [PW-1:0] prod;
            assign prod = PW'(crd_arr[a]) * PW'(src_arr[a]);
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    num_reg[0][a]  <= DB'({prod, {F{1'b0}}});
                    rem_reg[0][a]  <= '0;
                    quot_reg[0][a] <= '0;
                end
            end
        end

        for (k = 0; k < NS; k++)
        begin : g_div
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_valid_reg[k+1] <= 1'b0;
                end
                else if (advance)
                begin
                    dv_valid_reg[k+1] <= dv_valid_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    dv_kind_reg[k+1] <= dv_kind_reg[k];
                    dv_lidx_reg[k+1] <= dv_lidx_reg[k];
                    dv_lval_reg[k+1] <= dv_lval_reg[k];
                end
            end

            for (a = 0; a < 3; a++)
            begin : g_axis
                logic [DW-1:0]    rem_w;
                logic [STEPS-1:0] q_w;

                vtr_div_step #(
                    .STEPS (STEPS)
                ) u_step (
                    .rem_in   (rem_reg[k][a]),
                    .bits_in  (num_reg[k][a][DB-1 -: STEPS]),
                    .den      (dst_arr[a]),
                    .rem_out  (rem_w),
                    .quot_out (q_w)
                );

                always_ff @(posedge clk)
                begin
                    if (advance)
                    begin
                        num_reg[k+1][a]  <= num_reg[k][a] << STEPS;
                        rem_reg[k+1][a]  <= rem_w;
                        quot_reg[k+1][a] <= {quot_reg[k][a][DB-STEPS-1:0], q_w};
                    end
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Index stage: neighbour indices and fractions per axis
    // ------------------------------------------------------------------
    logic                        a_valid_reg;
    logic                        a_kind_reg;
    logic [vtr_pkg::LIDX_W-1:0]  a_lidx_reg;
    logic [vtr_pkg::LVAL_W-1:0]  a_lval_reg;
    logic [SB-1:0]               a_c0_reg [0:2];
    logic [SB-1:0]               a_c1_reg [0:2];
    logic [F-1:0]                a_f_reg  [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= dv_valid_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_kind_reg <= dv_kind_reg[NS];
            a_lidx_reg <= dv_lidx_reg[NS];
            a_lval_reg <= dv_lval_reg[NS];
        end
    end

    generate
        for (a = 0; a < 3; a++)
        begin : g_index
            logic [QB-1:0] q;
            logic [PW-1:0] ip;
            logic [PW:0]   last_e;
            logic [QB:0]   qr;
            logic [PW:0]   np;
            logic [SB-1:0] c0_next, c1_next;
            logic [F-1:0]  f_next;

            assign last_arr[a] = SB'(src_arr[a] - SEW'(1));
            assign q      = quot_reg[NS][a][QB-1:0];
            assign ip     = q[QB-1:F];
            assign last_e = (PW+1)'(last_arr[a]);
            assign qr     = {1'b0, q} + HALF;
            assign np     = qr[QB:F];

            always_comb
            begin
                if (mode_reg == vtr_pkg::MODE_TRILINEAR)
                begin
                    c0_next = ({1'b0, ip} > last_e) ? last_arr[a] : ip[SB-1:0];
                    c1_next = ({1'b0, ip} >= last_e) ? last_arr[a] : SB'(ip[SB-1:0] + 1'b1);
                    f_next  = q[F-1:0];
                end
                else
                begin
                    c0_next = (np > last_e) ? last_arr[a] : np[SB-1:0];
                    c1_next = c0_next;
                    f_next  = '0;
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    a_c0_reg[a] <= c0_next;
                    a_c1_reg[a] <= c1_next;
                    a_f_reg[a]  <= f_next;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Volume banks: bank = {z[0], y[0], x[0]}, address = coords >> 1
    // ------------------------------------------------------------------
    logic [IXW-1:0] lidx_ext;
    logic [SB-1:0]  lx, ly, lz;
    logic [SB-1:0]  lxh, lyh, lzh;
    logic           load_ok;
    logic [VB-1:0]  load_word;
    logic [VB-1:0]  rd_arr [0:7];

    assign lidx_ext  = IXW'(a_lidx_reg);
    assign lx        = lidx_ext[SB-1:0];
    assign ly        = lidx_ext[2*SB-1:SB];
    assign lz        = lidx_ext[3*SB-1:2*SB];
    assign lxh       = lx >> 1;
    assign lyh       = ly >> 1;
    assign lzh       = lz >> 1;
    assign load_ok   = a_valid_reg && (a_kind_reg == vtr_pkg::KIND_LOAD)
                       && ({1'b0, lidx_ext} < (IXW+1)'(VOL_DEPTH));
    assign load_word = VB'({{VB{1'b0}}, a_lval_reg});

    generate
        for (b = 0; b < 8; b++)
        begin : g_bank
            logic [SB-1:0]           sx, sy, sz;
            logic [SB-1:0]           hx, hy, hz;
            logic [3*HB-1:0]         raddr, waddr;
            logic                    bwe;

            // pick the neighbour on each axis that has this bank's parity
            assign sx = (a_c0_reg[0][0] == b[0]) ? a_c0_reg[0] : a_c1_reg[0];
            assign sy = (a_c0_reg[1][0] == b[1]) ? a_c0_reg[1] : a_c1_reg[1];
            assign sz = (a_c0_reg[2][0] == b[2]) ? a_c0_reg[2] : a_c1_reg[2];
            assign hx = sx >> 1;
            assign hy = sy >> 1;
            assign hz = sz >> 1;
            assign raddr = {hz[HB-1:0], hy[HB-1:0], hx[HB-1:0]};
            assign waddr = {lzh[HB-1:0], lyh[HB-1:0], lxh[HB-1:0]};
            assign bwe   = load_ok && (lx[0] == b[0]) && (ly[0] == b[1])
                           && (lz[0] == b[2]);

            vtr_ram #(
                .WIDTH (VB),
                .DEPTH (BANK_DEPTH)
            ) u_bank (
                .clk   (clk),
                .en    (advance),
                .we    (bwe),
                .addr  (bwe ? waddr : raddr),
                .wdata (load_word),
                .rdata (rd_arr[b])
            );
        end
    endgenerate

    // Stage beside the RAM output: parities and fractions
    logic         m_valid_reg;
    logic         m_p0_reg [0:2];
    logic         m_p1_reg [0:2];
    logic [F-1:0] m_f_reg  [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_valid_reg <= a_valid_reg && (a_kind_reg == vtr_pkg::KIND_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_p0_reg[i] <= a_c0_reg[i][0];
                m_p1_reg[i] <= a_c1_reg[i][0];
                m_f_reg[i]  <= a_f_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Blend: a + trunc((b - a) * f / 2^F), truncation toward zero
    // ------------------------------------------------------------------
    function automatic logic signed [LW-1:0] blend(
        input logic signed [LW-1:0] va,
        input logic signed [LW-1:0] vb,
        input logic [F-1:0]         f
    );
        logic signed [LW:0] d;
        logic [LW:0]        m;
        logic [LW+F:0]      p;
        logic [LW:0]        ps;
        logic signed [LW:0] ae;
        logic signed [LW:0] r;
        d  = {vb[LW-1], vb} - {va[LW-1], va};
        m  = d[LW] ? (LW+1)'(-d) : (LW+1)'(d);
        p  = (LW+F+1)'(m) * (LW+F+1)'(f);
        ps = p[LW+F:F];
        ae = {va[LW-1], va};
        r  = d[LW] ? (ae - $signed(ps)) : (ae + $signed(ps));
        return r[LW-1:0];
    endfunction

    // X blends
    logic                   x_valid_reg;
    logic signed [LW-1:0]   x_a_reg [0:3];
    logic [F-1:0]           x_fy_reg, x_fz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            x_valid_reg <= m_valid_reg;
        end
    end

    generate
        // yz index: bit 1 selects upper y, bit 0 upper z
        for (yz = 0; yz < 4; yz++)
        begin : g_xblend
            logic                 py, pz;
            logic signed [LW-1:0] va, vb;

            assign py = yz[1] ? m_p1_reg[1] : m_p0_reg[1];
            assign pz = yz[0] ? m_p1_reg[2] : m_p0_reg[2];
            assign va = LW'($signed(rd_arr[{pz, py, m_p0_reg[0]}])) <<< F;
            assign vb = LW'($signed(rd_arr[{pz, py, m_p1_reg[0]}])) <<< F;

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    x_a_reg[yz] <= blend(va, vb, m_f_reg[0]);
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_fy_reg <= m_f_reg[1];
            x_fz_reg <= m_f_reg[2];
        end
    end

    // Y blends
    logic                 y_valid_reg;
    logic signed [LW-1:0] y_b0_reg, y_b1_reg;
    logic [F-1:0]         y_fz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            y_valid_reg <= x_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            y_b0_reg <= blend(x_a_reg[0], x_a_reg[2], x_fy_reg);
            y_b1_reg <= blend(x_a_reg[1], x_a_reg[3], x_fy_reg);
            y_fz_reg <= x_fz_reg;
        end
    end

    // Z blend
    logic                 z_valid_reg;
    logic signed [LW-1:0] z_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            z_valid_reg <= y_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            z_r_reg <= blend(y_b0_reg, y_b1_reg, y_fz_reg);
        end
    end

    // ------------------------------------------------------------------
    // Output register: drop fraction, truncating toward zero
    // ------------------------------------------------------------------
    logic signed [LW-1:0]            rt;
    logic [vtr_pkg::SAMPLE_W-1:0]    out_data_reg;

    assign rt = z_r_reg[LW-1] ? ((z_r_reg + $signed(BIAS)) >>> F) : (z_r_reg >>> F);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= z_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= rt[vtr_pkg::SAMPLE_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/vtr_checker.sv @@
`default_nettype none

module vtr_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_stall,
    input wire logic                             out_valid,
    input wire logic                             out_stall,
    input wire logic [vtr_pkg::SAMPLE_W-1:0]     sample_value,
    input wire logic                             pready
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(sample_value))
        else $error("result changed while stalled");

    // Input stalls exactly when a result is held back
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output backpressure");

    // Configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind volume_trilinear_resampler_unit vtr_checker u_vtr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_value (sample_value),
    .pready       (pready)
);

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import vtr_pkg::*;

    localparam int SIDE = 32;
    localparam int VOL_N = SIDE * SIDE * SIDE;
    localparam int SUB = 6;
    localparam int FB = 16;
    localparam longint FONE = 64'sd1 << FB;
    localparam int PIPE_DRAIN = 24;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 1650;

    // Input transaction
    typedef struct {
        logic                     kind;
        logic [LIDX_W-1:0]        idx;
        logic signed [LVAL_W-1:0] val;
        logic [COORD_W-1:0]       x;
        logic [COORD_W-1:0]       y;
        logic [COORD_W-1:0]       z;
    } voxel_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic kind = KIND_LOAD;
    logic [LIDX_W-1:0] load_index = '0;
    logic signed [LVAL_W-1:0] load_value = '0;
    logic [COORD_W-1:0] out_x = '0;
    logic [COORD_W-1:0] out_y = '0;
    logic [COORD_W-1:0] out_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    // Shadow state of the block
    logic signed [LVAL_W-1:0] shadow_vol [VOL_N];
    int unsigned sh_src [3];
    int unsigned sh_dst [3];
    logic sh_mode;

    logic signed [SAMPLE_W-1:0] sample_q [$];
    int burst_left = 0;
    int mismatches = 0;
    int n_loads = 0;
    int n_samples = 0;
    int n_checked = 0;
    longint cycles = 0;

    volume_trilinear_resampler_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
        .load_index(load_index), .load_value(load_value),
        .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .out_valid(out_valid), .out_stall(out_stall), .sample_value(sample_value),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Effective source extent: zero reads as one, above the side saturates
    function automatic longint unsigned eff_src(int unsigned s);
        if (s == 0) return 1;
        if (s > SIDE) return SIDE;
        return s;
    endfunction

    function automatic longint unsigned map_coord(int unsigned o, int axis);
        longint unsigned d;
        d = (sh_dst[axis] == 0) ? 1 : sh_dst[axis];
        return ((longint'(o) * eff_src(sh_src[axis])) << FB) / d;
    endfunction

    function automatic longint unsigned clamp_axis(longint unsigned i, int axis);
        longint unsigned last;
        last = eff_src(sh_src[axis]) - 1;
        return (i > last) ? last : i;
    endfunction

    function automatic longint fetch_fixed(longint unsigned x, longint unsigned y,
                                           longint unsigned z);
        return longint'(shadow_vol[(z * SIDE + y) * SIDE + x]) * FONE;
    endfunction

    // a + trunc((b - a) * f / 2^FB), exact
    function automatic longint lerp_fixed(longint a, longint b, longint unsigned f);
        longint d;
        longint unsigned m;
        longint unsigned p;
        d = b - a;
        m = (d < 0) ? longint'(-d) : d;
        p = (m >> FB) * f + (((m & (FONE - 1)) * f) >> FB);
        return (d < 0) ? a - longint'(p) : a + longint'(p);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] resample_voxel(voxel_req_t r);
        longint unsigned pos [3];
        longint unsigned lo [3];
        longint unsigned hi [3];
        longint unsigned fr [3];
        longint a00, a01, a10, a11, b0, b1, res;
        pos[0] = map_coord(r.x, 0);
        pos[1] = map_coord(r.y, 1);
        pos[2] = map_coord(r.z, 2);
        if (sh_mode == MODE_TRILINEAR)
        begin
            for (int k = 0; k < 3; k++)
            begin
                fr[k] = pos[k] & (FONE - 1);
                lo[k] = clamp_axis(pos[k] >> FB, k);
                hi[k] = clamp_axis((pos[k] >> FB) + 1, k);
            end
            a00 = lerp_fixed(fetch_fixed(lo[0], lo[1], lo[2]),
                             fetch_fixed(hi[0], lo[1], lo[2]), fr[0]);
            a01 = lerp_fixed(fetch_fixed(lo[0], lo[1], hi[2]),
                             fetch_fixed(hi[0], lo[1], hi[2]), fr[0]);
            a10 = lerp_fixed(fetch_fixed(lo[0], hi[1], lo[2]),
                             fetch_fixed(hi[0], hi[1], lo[2]), fr[0]);
            a11 = lerp_fixed(fetch_fixed(lo[0], hi[1], hi[2]),
                             fetch_fixed(hi[0], hi[1], hi[2]), fr[0]);
            b0 = lerp_fixed(a00, a10, fr[1]);
            b1 = lerp_fixed(a01, a11, fr[1]);
            res = lerp_fixed(b0, b1, fr[2]) / FONE;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
                lo[k] = clamp_axis((pos[k] + (FONE >> 1)) >> FB, k);
            res = fetch_fixed(lo[0], lo[1], lo[2]) / FONE;
        end
        return res[SAMPLE_W-1:0];
    endfunction

    // Cycle count and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver stall pattern: phases of none, light, half and heavy stalling
    initial
    begin
        int style;
        int len;
        forever
        begin
            style = $urandom_range(0, 3);
            len = $urandom_range(10, 200);
            repeat (len)
            begin
                @(posedge clk);
                case (style)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 7) == 0);
                    2: out_stall <= $urandom_range(0, 1);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        logic signed [SAMPLE_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (sample_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result sample_value=%0d", sample_value);
            end
            else
            begin
                want = sample_q.pop_front();
                n_checked++;
                if (sample_value !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sample_value mismatch: expected %0d got %0d",
                                 want, sample_value);
                end
            end
        end
    end

    // One input transaction; the shadow state follows at acceptance
    task automatic send_item(voxel_req_t r);
        in_valid <= 1'b1;
        kind <= r.kind;
        load_index <= r.idx;
        load_value <= r.val;
        out_x <= r.x;
        out_y <= r.y;
        out_z <= r.z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (r.kind == KIND_LOAD)
        begin
            shadow_vol[r.idx] = r.val;
            n_loads++;
        end
        else
        begin
            sample_q.push_back(resample_voxel(r));
            n_samples++;
        end
        // sender bursts with random gaps
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 120)
                                                  : $urandom_range(0, 12);
            if ($urandom_range(0, 1))
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic load_voxel(int unsigned idx, int val);
        voxel_req_t r;
        r.kind = KIND_LOAD;
        r.idx = idx;
        r.val = val;
        r.x = $urandom_range(0, 254);
        r.y = $urandom_range(0, 254);
        r.z = $urandom_range(0, 254);
        send_item(r);
    endtask

    task automatic sample_at(int unsigned x, int unsigned y, int unsigned z);
        voxel_req_t r;
        r.kind = KIND_SAMPLE;
        r.idx = $urandom;
        r.val = $urandom;
        r.x = x;
        r.y = y;
        r.z = z;
        send_item(r);
    endtask

    // Drain the pipeline; loads leave nothing to wait on, so add the latency
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sample_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic apb_write(cfg_reg_t r, int unsigned value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_W'(4 * int'(r));
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_SRC_X: sh_src[0] = value & 6'h3f;
            REG_SRC_Y: sh_src[1] = value & 6'h3f;
            REG_SRC_Z: sh_src[2] = value & 6'h3f;
            REG_DST_X: sh_dst[0] = value & 8'hff;
            REG_DST_Y: sh_dst[1] = value & 8'hff;
            REG_DST_Z: sh_dst[2] = value & 8'hff;
            default:   sh_mode = value[0];
        endcase
    endtask

    task automatic set_geometry(int unsigned sx, int unsigned sy, int unsigned sz,
                                int unsigned dx, int unsigned dy, int unsigned dz,
                                logic mode);
        wait_idle();
        apb_write(REG_SRC_X, sx);
        apb_write(REG_SRC_Y, sy);
        apb_write(REG_SRC_Z, sz);
        apb_write(REG_DST_X, dx);
        apb_write(REG_DST_Y, dy);
        apb_write(REG_DST_Z, dz);
        apb_write(REG_MODE, mode);
    endtask

    // Corner block of SUB voxels per side written first; random-phase samples stay inside it
    task automatic test_fill_volume();
        for (int z = 0; z < SUB; z++)
            for (int y = 0; y < SUB; y++)
                for (int x = 0; x < SUB; x++)
                    load_voxel((z * SIDE + y) * SIDE + x, $urandom);
    endtask

    task automatic test_directed();
        // extreme values in the corners and a spot check at reset geometry
        load_voxel(0, -32768);
        load_voxel(1, 32767);
        load_voxel(VOL_N - 1, 32767);
        load_voxel(VOL_N - 2, -32768);
        sample_at(0, 0, 0);
        sample_at(254, 254, 254);
        sample_at(31, 31, 31);
        // destination of one: every nonzero coordinate lands beyond the volume
        set_geometry(32, 32, 32, 1, 1, 1, MODE_TRILINEAR);
        sample_at(0, 0, 0);
        sample_at(1, 2, 3);
        // source zero and oversized source, destination zero
        set_geometry(0, 63, 1, 0, 255, 255, MODE_TRILINEAR);
        sample_at(0, 30, 254);
        sample_at(3, 39, 7);
        // nearest mode with rounding on half steps
        set_geometry(3, 5, 32, 2, 2, 255, MODE_NEAREST);
        sample_at(1, 1, 20);
        sample_at(0, 0, 0);
        sample_at(254, 3, 40);
        set_geometry(32, 32, 32, 255, 255, 255, MODE_NEAREST);
        sample_at(254, 254, 254);
        sample_at(0, 0, 1);
    endtask

    // Random geometry phases, mostly samples with some voxel rewrites mixed in
    task automatic test_random_resample();
        int done;
        int phase;
        int unsigned s [3];
        int unsigned d [3];
        done = 0;
        phase = 0;
        while (done < RANDOM_ITEMS)
        begin
            for (int k = 0; k < 3; k++)
            begin
                case ($urandom_range(0, 4))
                    0: s[k] = SUB;
                    1: s[k] = 1;
                    2: s[k] = 0;
                    default: s[k] = $urandom_range(2, SUB);
                endcase
                case ($urandom_range(0, 4))
                    0: d[k] = 255;
                    1: d[k] = 1;
                    2: d[k] = $urandom_range(0, 255);
                    default: d[k] = $urandom_range(2, 64);
                endcase
            end
            set_geometry(s[0], s[1], s[2], d[0], d[1], d[2], phase % 2);
            repeat (150)
            begin
                if ($urandom_range(0, 3) == 0)
                    load_voxel(($urandom_range(0, SUB - 1) * SIDE
                                + $urandom_range(0, SUB - 1)) * SIDE
                               + $urandom_range(0, SUB - 1), $urandom);
                else if ($urandom_range(0, 5) == 0)
                    sample_at($urandom_range(0, 254), $urandom_range(0, 254),
                              $urandom_range(0, 254));
                else
                    sample_at($urandom_range(0, d[0]), $urandom_range(0, d[1]),
                              $urandom_range(0, d[2]));
                done++;
            end
            phase++;
        end
    endtask

    initial
    begin
        for (int k = 0; k < 3; k++)
        begin
            sh_src[k] = SRC_RESET;
            sh_dst[k] = DST_RESET;
        end
        sh_mode = MODE_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_volume();
        test_directed();
        test_random_resample();

        wait_idle();
        $display("Ran %0d voxel loads and %0d resample transactions, %0d results checked",
                 n_loads, n_samples, n_checked);
        $display("Both interpolation modes over random and extreme geometries");
        if (mismatches == 0 && sample_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
